[rtl/ttr_pkg.sv]
// Package: shared constants, payload types and pipeline structs of the tensor tile repeater.
package ttr_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ELEM_WIDTH  = 64;
    localparam int REP_MAX     = 255;

    localparam int AW       = $clog2(STORE_DEPTH);
    localparam int LPW      = AW + 1;
    localparam int CW       = 12;
    localparam int DW       = 13;
    localparam int RW       = 8;
    localparam int FIELD_W  = 64;
    localparam int SIZE_MAX = 4096;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 13;
    localparam int PW       = AW + DW + 1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [CFG_IW-1:0] REG_ROWS       = 3'd0;
    localparam logic [CFG_IW-1:0] REG_COLS       = 3'd1;
    localparam logic [CFG_IW-1:0] REG_SLICES     = 3'd2;
    localparam logic [CFG_IW-1:0] REG_HYPER      = 3'd3;
    localparam logic [CFG_IW-1:0] REG_REP_ROWS   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_REP_COLS   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_REP_SLICES = 3'd6;
    localparam logic [CFG_IW-1:0] REG_REP_HYPER  = 3'd7;

    typedef struct packed {
        logic               cmd;
        logic [FIELD_W-1:0] value_in;
        logic               load_last;
        logic               col_major;
    } ttr_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] value_out;
        logic               out_last;
    } ttr_out_t;

    typedef struct packed {
        logic                  fetch;
        logic                  load;
        logic                  last;
        logic                  over;
        logic [AW-1:0]         addr;
        logic [ELEM_WIDTH-1:0] wdata;
        logic [3:0][CW-1:0]    cnt;
        logic [2:0][DW-1:0]    mul;
    } ttr_pipe_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic over;
    } ttr_rsp_t;

endpackage

[rtl/tensor_tile_repeater.sv]
// Top level: four-dimensional tensor tiling, load then fetch, with a registered result.
// Takes one transfer per cycle, busy held low; the receiver cannot stall. A fetch result is
// registered in turn by the input register, three multiply-add stages, the store read and
// the output register.
// Loads and fetches pass through the same stages, so store writes keep their order.
// Asynchronous active-low reset: sizes and repeats to one, walk idle, store undefined.
module tensor_tile_repeater
    import ttr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ttr_in_t           item,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output logic              result_strobe,
    output ttr_out_t          result
);

    ttr_pipe_t             ctrl_pipe;
    ttr_pipe_t             addr_pipe;
    ttr_rsp_t              rsp;
    logic [ELEM_WIDTH-1:0] rdata;
    logic                  strobe_reg;
    ttr_out_t              result_reg;

    assign busy = 1'b0;

    ttr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (start && !busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pipe      (ctrl_pipe)
    );

    ttr_addr u_addr
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .pipe_in  (ctrl_pipe),
        .pipe_out (addr_pipe)
    );

    ttr_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pipe_in (addr_pipe),
        .rsp     (rsp),
        .rdata   (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= rsp.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.value_out <= rsp.over ? '0 : FIELD_W'(rdata);
        result_reg.out_last  <= rsp.last;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

[rtl/ttr_ctrl.sv]
// Control: configuration registers, load pointer, walk counters and the input register.
module ttr_ctrl
    import ttr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  ttr_in_t             item,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    output ttr_pipe_t           pipe
);

    logic [DW-1:0]  sizes_reg [4];
    logic [RW-1:0]  reps_reg  [4];
    logic [LPW-1:0] lp_reg, lp_next;
    logic [CW-1:0]  inner_reg [4];
    logic [CW-1:0]  inner_next [4];
    logic [RW-1:0]  rep_reg [4];
    logic [RW-1:0]  rep_next [4];
    logic           layout_reg, layout_next;
    logic           emit_reg, emit_next;
    ttr_pipe_t      pipe_reg, pipe_next;

    logic [DW-1:0]  size_sat;
    logic [RW-1:0]  rep_sat;
    logic           any_zero;

    assign size_sat = (cfg_data > DW'(SIZE_MAX)) ? DW'(SIZE_MAX) : cfg_data;
    assign rep_sat  = (32'(cfg_data[RW-1:0]) > REP_MAX) ? RW'(REP_MAX) : cfg_data[RW-1:0];

    always_comb
    begin
        any_zero = 1'b0;
        for (int d = 0; d < 4; d++)
        begin
            if (sizes_reg[d] == '0 || reps_reg[d] == '0)
            begin
                any_zero = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic       carry;
        logic [1:0] d;
        logic [DW-1:0] inc;
        logic [RW:0]   rinc;

        lp_next     = lp_reg;
        layout_next = layout_reg;
        emit_next   = emit_reg;
        inner_next  = inner_reg;
        rep_next    = rep_reg;
        pipe_next   = pipe_reg;
        pipe_next.fetch = 1'b0;
        pipe_next.load  = 1'b0;
        carry = 1'b0;
        d     = 2'd0;
        inc   = '0;
        rinc  = '0;

        if (accept)
        begin
            if (item.cmd == CMD_LOAD)
            begin
                emit_next = 1'b0;
                pipe_next.addr  = lp_reg[AW-1:0];
                pipe_next.over  = 1'b0;
                pipe_next.wdata = item.value_in[ELEM_WIDTH-1:0];
                if (32'(lp_reg) < STORE_DEPTH)
                begin
                    pipe_next.load = 1'b1;
                    lp_next = lp_reg + LPW'(1);
                end
                if (item.load_last)
                begin
                    lp_next     = '0;
                    layout_next = item.col_major;
                    for (int k = 0; k < 4; k++)
                    begin
                        inner_next[k] = '0;
                        rep_next[k]   = '0;
                    end
                    emit_next = !any_zero;
                end
            end
            else if (emit_reg)
            begin
                if (any_zero)
                begin
                    emit_next = 1'b0;
                end
                else
                begin
                    pipe_next.fetch = 1'b1;
                    for (int i = 0; i < 4; i++)
                    begin
                        pipe_next.cnt[i] = layout_reg ? inner_reg[3 - i] : inner_reg[i];
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        pipe_next.mul[i] = layout_reg ? sizes_reg[2 - i] : sizes_reg[i + 1];
                    end
                    pipe_next.addr = AW'(pipe_next.cnt[0]);
                    pipe_next.over = (32'(pipe_next.cnt[0]) >= STORE_DEPTH);

                    carry = 1'b1;
                    for (int k = 0; k < 4; k++)
                    begin
                        d = layout_reg ? 2'(k) : 2'(3 - k);
                        if (carry)
                        begin
                            inc = DW'(inner_reg[d]) + DW'(1);
                            if (inc >= sizes_reg[d])
                            begin
                                inner_next[d] = '0;
                                rinc = {1'b0, rep_reg[d]} + (RW+1)'(1);
                                if (rinc >= {1'b0, reps_reg[d]})
                                begin
                                    rep_next[d] = '0;
                                end
                                else
                                begin
                                    rep_next[d] = rinc[RW-1:0];
                                    carry = 1'b0;
                                end
                            end
                            else
                            begin
                                inner_next[d] = inc[CW-1:0];
                                carry = 1'b0;
                            end
                        end
                    end
                    pipe_next.last = carry;
                    if (carry)
                    begin
                        emit_next = 1'b0;
                        for (int k = 0; k < 4; k++)
                        begin
                            inner_next[k] = '0;
                            rep_next[k]   = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < 4; d++)
            begin
                sizes_reg[d] <= DW'(1);
                reps_reg[d]  <= RW'(1);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS:       sizes_reg[0] <= size_sat;
                REG_COLS:       sizes_reg[1] <= size_sat;
                REG_SLICES:     sizes_reg[2] <= size_sat;
                REG_HYPER:      sizes_reg[3] <= size_sat;
                REG_REP_ROWS:   reps_reg[0]  <= rep_sat;
                REG_REP_COLS:   reps_reg[1]  <= rep_sat;
                REG_REP_SLICES: reps_reg[2]  <= rep_sat;
                REG_REP_HYPER:  reps_reg[3]  <= rep_sat;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg     <= '0;
            layout_reg <= 1'b0;
            emit_reg   <= 1'b0;
            pipe_reg   <= '0;
            for (int d = 0; d < 4; d++)
            begin
                inner_reg[d] <= '0;
                rep_reg[d]   <= '0;
            end
        end
        else
        begin
            lp_reg     <= lp_next;
            layout_reg <= layout_next;
            emit_reg   <= emit_next;
            pipe_reg   <= pipe_next;
            inner_reg  <= inner_next;
            rep_reg    <= rep_next;
        end
    end

    assign pipe = pipe_reg;

endmodule

[rtl/ttr_addr.sv]
// Address pipeline: three registered multiply-add steps that form the source address.
module ttr_addr
    import ttr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ttr_pipe_t pipe_in,
    output ttr_pipe_t pipe_out
);

    ttr_pipe_t stage_reg  [3];
    ttr_pipe_t stage_next [3];
    ttr_pipe_t stage_in   [3];

    assign stage_in[0] = pipe_in;
    assign stage_in[1] = stage_reg[0];
    assign stage_in[2] = stage_reg[1];

    always_comb
    begin
        logic [PW-1:0] prod;

        prod = '0;
        for (int i = 0; i < 3; i++)
        begin
            stage_next[i] = stage_in[i];
            if (stage_in[i].fetch && !stage_in[i].over)
            begin
                prod = PW'(stage_in[i].addr) * PW'(stage_in[i].mul[i])
                     + PW'(stage_in[i].cnt[i + 1]);
                stage_next[i].over = (prod >= PW'(STORE_DEPTH));
                stage_next[i].addr = prod[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                stage_reg[i] <= '0;
            end
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign pipe_out = stage_reg[2];

endmodule

[rtl/ttr_store.sv]
// Element store: one write or one registered read per cycle, in pipeline order.
module ttr_store
    import ttr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ttr_pipe_t             pipe_in,
    output ttr_rsp_t              rsp,
    output logic [ELEM_WIDTH-1:0] rdata
);

    logic [ELEM_WIDTH-1:0] mem [STORE_DEPTH];
    logic [ELEM_WIDTH-1:0] rdata_reg;
    ttr_rsp_t              rsp_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_in.load)
        begin
            mem[pipe_in.addr] <= pipe_in.wdata;
        end
        rdata_reg <= mem[pipe_in.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_reg <= '0;
        end
        else
        begin
            rsp_reg.valid <= pipe_in.fetch;
            rsp_reg.last  <= pipe_in.last;
            rsp_reg.over  <= pipe_in.over;
        end
    end

    assign rsp   = rsp_reg;
    assign rdata = rdata_reg;

endmodule

[tb/tile_check_pkg.sv]
// Scoreboard class: predicts the tiled output stream and checks each result transfer against it.
package tile_check_pkg;

    import ttr_pkg::*;

    class tile_scoreboard;

        logic [ELEM_WIDTH-1:0] tensor_words [STORE_DEPTH];
        int unsigned           load_ptr;
        int unsigned           inner [4];
        int unsigned           rep_cnt [4];
        int unsigned           dim [4];
        int unsigned           rep [4];
        bit                    col_order;
        bit                    armed;
        ttr_out_t              due_elems [$];
        int                    errors;

        function new();
            for (int d = 0; d < 4; d++)
            begin
                tensor_words[d] = '0;
                inner[d]        = 0;
                rep_cnt[d]      = 0;
                dim[d]          = 1;
                rep[d]          = 1;
            end
            load_ptr  = 0;
            col_order = 1'b0;
            armed     = 1'b0;
            errors    = 0;
        endfunction

        task report(string msg);
            if (errors < 50)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            errors++;
        endtask

        function int outstanding();
            return due_elems.size();
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
            int unsigned v;
            if (idx < REG_REP_ROWS)
            begin
                v        = data;
                dim[idx] = (v > SIZE_MAX) ? SIZE_MAX : v;
            end
            else
            begin
                v                       = data[RW-1:0];
                rep[idx - REG_REP_ROWS] = (v > REP_MAX) ? REP_MAX : v;
            end
        endfunction

        function bit has_zero();
            for (int d = 0; d < 4; d++)
            begin
                if (dim[d] == 0 || rep[d] == 0)
                begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void clear_walk();
            for (int d = 0; d < 4; d++)
            begin
                inner[d]   = 0;
                rep_cnt[d] = 0;
            end
        endfunction

        function longint unsigned source_addr();
            longint unsigned a;
            if (col_order)
            begin
                a = inner[3];
                a = a * dim[2] + inner[2];
                a = a * dim[1] + inner[1];
                a = a * dim[0] + inner[0];
            end
            else
            begin
                a = inner[0];
                a = a * dim[1] + inner[1];
                a = a * dim[2] + inner[2];
                a = a * dim[3] + inner[3];
            end
            return a;
        endfunction

        // advance the walk; true once the whole tiled output is done
        function bit step_walk();
            int d;
            for (int k = 0; k < 4; k++)
            begin
                d = col_order ? k : 3 - k;
                if (inner[d] + 1 < dim[d])
                begin
                    inner[d]++;
                    return 1'b0;
                end
                inner[d] = 0;
                if (rep_cnt[d] + 1 < rep[d])
                begin
                    rep_cnt[d]++;
                    return 1'b0;
                end
                rep_cnt[d] = 0;
            end
            return 1'b1;
        endfunction

        function void note_transfer(ttr_in_t it);
            ttr_out_t        want;
            longint unsigned addr;
            if (it.cmd == CMD_LOAD)
            begin
                armed = 1'b0;
                if (load_ptr < STORE_DEPTH)
                begin
                    tensor_words[load_ptr] = it.value_in;
                    load_ptr++;
                end
                if (it.load_last)
                begin
                    load_ptr  = 0;
                    col_order = it.col_major;
                    clear_walk();
                    armed = !has_zero();
                end
                return;
            end
            if (!armed)
            begin
                return;
            end
            if (has_zero())
            begin
                armed = 1'b0;
                return;
            end
            addr           = source_addr();
            want.value_out = (addr < STORE_DEPTH) ? tensor_words[addr] : '0;
            want.out_last  = step_walk();
            if (want.out_last)
            begin
                armed = 1'b0;
                clear_walk();
            end
            due_elems.push_back(want);
        endfunction

        task check_result(ttr_out_t got);
            ttr_out_t want;
            if (due_elems.size() == 0)
            begin
                report($sformatf("unexpected result value_out=%h out_last=%0b",
                                 got.value_out, got.out_last));
                return;
            end
            want = due_elems.pop_front();
            if (got.value_out !== want.value_out)
            begin
                report($sformatf("value_out %h, want %h", got.value_out, want.value_out));
            end
            if (got.out_last !== want.out_last)
            begin
                report($sformatf("out_last %0b, want %0b", got.out_last, want.out_last));
            end
        endtask

    endclass

endpackage

[tb/tensor_tile_repeater_test.sv]
// Testbench top: drives loads, fetches and register writes into the tensor tile repeater.
module tensor_tile_repeater_test;

    import ttr_pkg::*;
    import tile_check_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 12;
    localparam int LATENCY        = 6;
    localparam int SETTLE         = LATENCY + 4;
    localparam int DRAIN_LIMIT    = 200;
    localparam int NUM_REGS       = 8;
    localparam int RANDOM_ITEMS   = 600;
    localparam int TIMEOUT_CYCLES = 600000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    ttr_in_t           item      = '0;
    logic              cfg_we    = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;
    logic              result_strobe;
    ttr_out_t          result;

    tile_scoreboard sb;
    int             idle_pct;
    int             random_items;
    int             idle_plan [4] = '{0, 55, 0, 34};

    tensor_tile_repeater DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .result        (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_transfer(item);
            end
            if (result_strobe)
            begin
                sb.check_result(result);
            end
        end
    end

    function automatic logic [FIELD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(ttr_in_t it);
        if ($urandom_range(1, 100) <= idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
    endtask

    task automatic send_load(logic [FIELD_W-1:0] v, logic last, logic colm);
        ttr_in_t it;
        it.cmd       = CMD_LOAD;
        it.value_in  = v;
        it.load_last = last;
        it.col_major = colm;
        send_item(it);
    endtask

    task automatic send_fetch();
        ttr_in_t it;
        it.cmd       = CMD_FETCH;
        it.value_in  = rand_word();
        it.load_last = 1'($urandom_range(0, 1));
        it.col_major = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && sb.outstanding() != 0; n++)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_shape(input logic [CFG_DW-1:0] r, c, s, h, rr, rc, rs, rh);
        logic [CFG_DW-1:0] vals [NUM_REGS];
        vals[REG_ROWS]       = r;
        vals[REG_COLS]       = c;
        vals[REG_SLICES]     = s;
        vals[REG_HYPER]      = h;
        vals[REG_REP_ROWS]   = rr;
        vals[REG_REP_COLS]   = rc;
        vals[REG_REP_SLICES] = rs;
        vals[REG_REP_HYPER]  = rh;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IW'(i);
            cfg_data  <= vals[i];
            sb.write_reg(CFG_IW'(i), vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_tile_sequence();
        int unsigned dim_v [4];
        int unsigned rep_v [4];
        int unsigned elems;
        int unsigned outs;
        int unsigned n_load;
        int unsigned n_fetch;
        int unsigned kind;
        int unsigned z;
        logic        colm;
        logic        last;
        ttr_in_t     noise;
        kind = $urandom_range(0, 9);
        do
        begin
            elems = 1;
            outs  = 1;
            for (int d = 0; d < 4; d++)
            begin
                dim_v[d] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6)
                                                       : $urandom_range(1, 2);
                rep_v[d] = $urandom_range(1, 3);
                elems *= dim_v[d];
                outs  *= dim_v[d] * rep_v[d];
            end
        end
        while (outs > 64);
        if (kind == 0)
        begin
            z = $urandom_range(0, 7);
            if (z < 4)
            begin
                dim_v[z] = 0;
            end
            else
            begin
                rep_v[z - 4] = 0;
            end
            outs = 0;
        end
        drain();
        program_shape(CFG_DW'(dim_v[0]), CFG_DW'(dim_v[1]),
                      CFG_DW'(dim_v[2]), CFG_DW'(dim_v[3]),
                      CFG_DW'(rep_v[0] | ($urandom_range(0, 31) << RW)),
                      CFG_DW'(rep_v[1] | ($urandom_range(0, 31) << RW)),
                      CFG_DW'(rep_v[2] | ($urandom_range(0, 31) << RW)),
                      CFG_DW'(rep_v[3] | ($urandom_range(0, 31) << RW)));
        n_load = (kind == 1) ? $urandom_range(1, elems + 3) : elems;
        colm   = 1'($urandom_range(0, 1));
        for (int unsigned i = 0; i < n_load; i++)
        begin
            last = (i == n_load - 1) && !(kind == 1 && $urandom_range(0, 3) == 0);
            send_load(rand_word(), last, last ? colm : 1'($urandom_range(0, 1)));
            random_items++;
        end
        n_fetch = (outs == 0) ? $urandom_range(1, 3)
                : (kind == 2) ? $urandom_range(1, outs) : outs;
        for (int unsigned i = 0; i < n_fetch; i++)
        begin
            if (kind == 3 && $urandom_range(0, 5) == 0)
            begin
                noise = {1'($urandom_range(0, 1)), rand_word(), 2'($urandom_range(0, 3))};
                send_item(noise);
                random_items++;
            end
            send_fetch();
            random_items++;
        end
        repeat ($urandom_range(0, 2)) send_fetch();
    endtask

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        sb           = new();
        idle_pct     = 0;
        random_items = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fetch while idle
        send_fetch();
        send_fetch();
        // fill the whole store, overflow, then a one-element walk
        for (int i = 0; i < STORE_DEPTH + 3; i++)
        begin
            send_load(rand_word(), i == STORE_DEPTH + 2, 1'($urandom_range(0, 1)));
        end
        send_fetch();
        send_fetch();
        drain();

        // small tensor, column-major then row-major
        program_shape(2, 2, 1, 2, 1, 2, 1, 1);
        send_load('1, 1'b0, 1'b0);
        send_load('0, 1'b0, 1'b1);
        send_load(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
        send_load(64'h5555_5555_5555_5555, 1'b0, 1'b1);
        send_load(64'h8000_0000_0000_0001, 1'b0, 1'b0);
        send_load(rand_word(), 1'b0, 1'b0);
        send_load(rand_word(), 1'b0, 1'b0);
        send_load(rand_word(), 1'b1, 1'b1);
        repeat (16) send_fetch();
        send_load(64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
        repeat (16) send_fetch();
        drain();

        // zero size, then zero repeat: no arming
        program_shape(0, 1, 1, 1, 1, 1, 1, 1);
        send_load(rand_word(), 1'b1, 1'b1);
        send_fetch();
        drain();
        program_shape(1, 1, 1, 1, 1, 1, 1, 0);
        send_load(rand_word(), 1'b1, 1'b0);
        send_fetch();
        drain();

        // zero found by a fetch drops the armed walk
        program_shape(2, 1, 1, 1, 1, 1, 1, 1);
        send_load(rand_word(), 1'b1, 1'b1);
        send_fetch();
        drain();
        program_shape(2, 1, 1, 1, 1, 1, 0, 1);
        send_fetch();
        drain();
        program_shape(2, 1, 1, 1, 1, 1, 1, 1);
        send_fetch();
        drain();

        // shrink a size mid-walk: counter past its new limit wraps
        program_shape(4, 3, 1, 1, 1, 1, 1, 1);
        send_load(rand_word(), 1'b1, 1'b1);
        repeat (3) send_fetch();
        drain();
        program_shape(2, 3, 1, 1, 1, 1, 1, 1);
        repeat (6) send_fetch();
        drain();

        // saturated registers; walk past the store, then interrupt with a load
        program_shape(2, 1, 1, 2, 13'h1FFF, 13'h1F01, 13'h1E01, 13'h0101);
        send_load(rand_word(), 1'b1, 1'b0);
        repeat (2) send_fetch();
        drain();
        program_shape(2, 1, 1, 13'h1FFF, 13'h1FFF, 13'h1F01, 13'h1E01, 13'h0101);
        repeat (4) send_fetch();
        send_load(rand_word(), 1'b0, 1'b0);
        send_fetch();
        drain();

        while (random_items < RANDOM_ITEMS)
        begin
            idle_pct = idle_plan[(random_items / 150) % 4];
            run_tile_sequence();
        end

        drain();
        if (sb.outstanding() != 0)
        begin
            sb.report($sformatf("%0d results still due at end of run", sb.outstanding()));
        end
        if (sb.errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
